// ===== src/kmp_pkg.sv =====
`timescale 1ns / 1ps

package kmp_pkg;

	localparam int unsigned PATTERN_MAX_DEF   = 256;
	localparam int unsigned POSITION_BITS_DEF = 32;
	localparam int unsigned START_W           = 32;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_TEXT   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

endpackage

// ===== src/kmp_stream_matcher.sv =====
`timescale 1ns / 1ps
// Clear, no-op and rejected items and the first pattern byte are registered into S_FIN, which
// holds them while the output is pending. Other pattern and text bytes go through S_WALK, one
// failure-link step per read of the pattern and failure memories, until the walk ends and the output is free.
// A new transaction is taken only when the previous item has left S_WALK and S_FIN.
// Reset clears the control and length registers asynchronously; the memories are not cleared.

module kmp_stream_matcher
	import kmp_pkg::*;
#(
	parameter int unsigned PATTERN_MAX   = PATTERN_MAX_DEF,
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
	localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               match_found,
	output logic [START_W-1:0] match_start,
	output logic [LEN_W-1:0]   matched_length,
	output logic [1:0]         status
);

	localparam int unsigned POS_W = POSITION_BITS;
	localparam int unsigned AW    = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int unsigned MW    = (POS_W > START_W) ? POS_W : START_W;

	logic [7:0]       pat_mem  [PATTERN_MAX];
	logic [IDX_W-1:0] fail_mem [PATTERN_MAX];

	state_t           state_q;
	logic [LEN_W-1:0] length_q;
	logic [IDX_W-1:0] build_q;
	logic [IDX_W-1:0] match_q;
	logic [POS_W-1:0] pos_q;
	logic [IDX_W-1:0] j_q;
	logic [7:0]       c_q;
	logic [1:0]       func_q;
	logic [7:0]       pat_rd_q;
	logic [IDX_W-1:0] fail_rd_q;

	logic               res_found_q;
	logic [START_W-1:0] res_start_q;
	logic [LEN_W-1:0]   res_len_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;

	logic             accept;
	logic             out_free;
	logic             step;
	logic             walk_done;
	logic [LEN_W-1:0] j_fin;
	logic             hit;
	logic [IDX_W-1:0] j0;
	logic [IDX_W-1:0] rd_j;
	logic [IDX_W-1:0] fail_raddr;
	logic             pat_we;
	logic             fail_we;
	logic [IDX_W-1:0] fail_wdata;
	logic [IDX_W-1:0] wr_idx;
	logic [AW-1:0]    start_a;
	logic [MW-1:0]    start_m;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign step      = (j_q != '0) && (pat_rd_q != c_q);
	assign walk_done = (state_q == S_WALK) && !step && out_free;
	assign j_fin     = (pat_rd_q == c_q) ? (LEN_W'(j_q) + LEN_W'(1)) : '0;
	assign hit       = (j_fin == length_q);
	assign wr_idx    = length_q[IDX_W-1:0];

	assign start_a = AW'(pos_q) - AW'(length_q) + AW'(1);
	assign start_m = MW'(start_a[POS_W-1:0]);

	always_comb begin
		if (func == FUNC_APPEND) begin
			j0 = (LEN_W'(build_q) >= length_q) ? '0 : build_q;
		end else begin
			j0 = (LEN_W'(match_q) >= length_q) ? '0 : match_q;
		end
	end

	always_comb begin
		rd_j       = j_q;
		pat_we     = 1'b0;
		fail_we    = 1'b0;
		fail_wdata = '0;
		case (state_q)
			S_IDLE: begin
				rd_j = j0;
				if (accept && func == FUNC_APPEND && length_q < LEN_W'(PATTERN_MAX)) begin
					pat_we = 1'b1;
					if (length_q == '0) begin
						fail_we = 1'b1;
					end
				end
			end
			S_WALK: begin
				if (step) begin
					rd_j = fail_rd_q;
				end
				if (walk_done && func_q == FUNC_APPEND) begin
					fail_we    = 1'b1;
					fail_wdata = j_fin[IDX_W-1:0];
				end
			end
			default: begin
				rd_j = j_q;
			end
		endcase
	end

	assign fail_raddr = (rd_j == '0) ? '0 : (rd_j - IDX_W'(1));

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[wr_idx] <= data_byte;
		end
		pat_rd_q <= pat_mem[rd_j];
	end

	always_ff @(posedge clk) begin
		if (fail_we) begin
			fail_mem[wr_idx] <= fail_wdata;
		end
		fail_rd_q <= fail_mem[fail_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			build_q     <= '0;
			match_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						c_q          <= data_byte;
						func_q       <= func;
						res_found_q  <= 1'b0;
						res_start_q  <= '0;
						res_len_q    <= LEN_W'(match_q);
						res_status_q <= ST_OK;
						state_q      <= S_FIN;
						case (func)
							FUNC_CLEAR: begin
								length_q  <= '0;
								build_q   <= '0;
								match_q   <= '0;
								pos_q     <= '0;
								res_len_q <= '0;
							end
							FUNC_APPEND: begin
								if (length_q >= LEN_W'(PATTERN_MAX)) begin
									res_status_q <= ST_FULL;
								end else if (length_q == '0) begin
									build_q  <= '0;
									length_q <= LEN_W'(1);
								end else begin
									state_q <= S_WALK;
								end
							end
							FUNC_TEXT: begin
								if (length_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_WALK;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_WALK: begin
					if (walk_done) begin
						out_valid_q    <= 1'b1;
						match_found    <= 1'b0;
						match_start    <= '0;
						matched_length <= LEN_W'(match_q);
						status         <= ST_OK;
						state_q        <= S_IDLE;
						if (func_q == FUNC_APPEND) begin
							build_q  <= j_fin[IDX_W-1:0];
							length_q <= length_q + LEN_W'(1);
						end else begin
							pos_q <= pos_q + POS_W'(1);
							if (hit) begin
								match_q        <= '0;
								match_found    <= 1'b1;
								match_start    <= start_m[START_W-1:0];
								matched_length <= '0;
							end else begin
								match_q        <= j_fin[IDX_W-1:0];
								matched_length <= j_fin;
							end
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						match_found    <= res_found_q;
						match_start    <= res_start_q;
						matched_length <= res_len_q;
						status         <= res_status_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE || step) begin
			j_q <= rd_j;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_hit_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && match_found) |-> (matched_length == '0 && status == ST_OK))
		else $error("match reported without restart of the matched prefix");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LEN_W'(PATTERN_MAX))
		else $error("pattern length beyond store depth");

	a_walk_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (LEN_W'(j_q) < length_q))
		else $error("failure walk outside the stored pattern");

	a_walk_holds_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && out_valid_q && !out_ready) |=> (state_q != S_IDLE || step == 1'b0))
		else $error("walk finished while the output transaction was pending");
`endif

endmodule

// ===== tb/kmp_stream_matcher_test.sv =====
`timescale 1ns / 1ps

module kmp_stream_matcher_test;
	import kmp_pkg::*;

	localparam int unsigned PAT_MAX = PATTERN_MAX_DEF;
	localparam int unsigned LEN_W = $clog2(PAT_MAX + 1);
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int unsigned ITEM_TARGET = 1550;
	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned REPORT_MAX = 10;
	localparam int unsigned DIRECTED_ROWS = 25;

	typedef struct packed {
		logic                 found;
		logic [START_W-1:0]   start;
		logic [LEN_W-1:0]     len;
		logic [1:0]           status;
	} kmp_result_t;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  data;
		bit          typed;
		kmp_result_t want;
	} step_row_t;

	localparam kmp_result_t RES_ZERO = '{found: 1'b0, start: '0, len: '0, status: ST_OK};
	localparam kmp_result_t RES_EMPTY = '{found: 1'b0, start: '0, len: '0, status: ST_EMPTY};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         func;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_ready;
	logic               match_found;
	logic [START_W-1:0] match_start;
	logic [LEN_W-1:0]   matched_length;
	logic [1:0]         status;

	kmp_stream_matcher dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_found    (match_found),
		.match_start    (match_start),
		.matched_length (matched_length),
		.status         (status)
	);

	logic [7:0]         pat_bytes [PAT_MAX];
	int unsigned        pat_links [PAT_MAX];
	int unsigned        pat_len;
	int unsigned        build_len;
	int unsigned        text_len;
	logic [START_W-1:0] text_pos;

	kmp_result_t pending_results [$];
	step_row_t   directed_rows [DIRECTED_ROWS];
	logic [7:0]  alphabet [3];
	int unsigned alpha_n;
	bit          steady;
	bit          big_done;

	int unsigned errors;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned matches_seen;
	int unsigned full_seen;
	int unsigned empty_seen;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned extend_prefix(int unsigned j, logic [7:0] c);
		int unsigned k;
		k = j;
		while (k > 0 && k < PAT_MAX && pat_bytes[k] != c)
			k = pat_links[k - 1];
		if (k < PAT_MAX && pat_bytes[k] == c)
			k++;
		return k;
	endfunction

	function automatic kmp_result_t next_match_result(logic [1:0] op, logic [7:0] c);
		kmp_result_t r;
		int unsigned j;
		r = RES_ZERO;
		case (op)
			FUNC_CLEAR: begin
				pat_len = 0;
				build_len = 0;
				text_len = 0;
				text_pos = '0;
			end
			FUNC_APPEND: begin
				if (pat_len >= PAT_MAX) begin
					r.status = ST_FULL;
				end else begin
					pat_bytes[pat_len] = c;
					if (pat_len == 0) begin
						build_len = 0;
					end else begin
						j = (build_len >= pat_len) ? 0 : build_len;
						build_len = extend_prefix(j, c);
					end
					pat_links[pat_len] = build_len;
					pat_len++;
				end
			end
			FUNC_TEXT: begin
				if (pat_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					j = (text_len >= pat_len) ? 0 : text_len;
					j = extend_prefix(j, c);
					if (j == pat_len) begin
						r.found = 1'b1;
						r.start = text_pos - START_W'(pat_len) + 1'b1;
						j = 0;
					end
					text_len = j;
					text_pos = text_pos + 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.len = LEN_W'(text_len);
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom);
		return alphabet[$urandom_range(0, alpha_n - 1)];
	endfunction

	task automatic report_failure(string what, kmp_result_t want, kmp_result_t got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0t %s: found %0d/%0d start %0d/%0d length %0d/%0d status %0d/%0d",
				$time, what, want.found, got.found, want.start, got.start,
				want.len, got.len, want.status, got.status);
	endtask

	task automatic send_item(input logic [1:0] op, input logic [7:0] val,
			input bit typed = 1'b0, input kmp_result_t want = RES_ZERO);
		int unsigned gap;
		kmp_result_t predicted;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		data_byte <= val;
		do @(posedge clk); while (!in_ready);
		predicted = next_match_result(op, val);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		if (op != FUNC_NOP)
			items_sent++;
	endtask

	// A clear (always in the large variant), a pattern mostly from a small alphabet, then text mostly
	// from it so partial and full matches are frequent; the large variant sends 250-262 pattern bytes.
	task automatic run_pattern_search(input bit big);
		int unsigned plen;
		int unsigned tlen;
		int unsigned r;
		steady = ($urandom_range(0, 7) == 0);
		alphabet[0] = 8'($urandom);
		alphabet[1] = alphabet[0] ^ (8'd1 << $urandom_range(0, 7));
		alphabet[2] = 8'($urandom);
		alpha_n = big ? 1 : $urandom_range(1, 3);
		if (big)
			big_done = 1'b1;
		if (big || pat_len == 0 || $urandom_range(0, 4) != 0)
			send_item(FUNC_CLEAR, 8'($urandom));
		if (big)
			plen = $urandom_range(250, 262);
		else if ($urandom_range(0, 9) < 8)
			plen = $urandom_range(1, 6);
		else
			plen = $urandom_range(7, 40);
		for (int unsigned i = 0; i < plen; i++)
			send_item(FUNC_APPEND, big ? alphabet[0] : pick_symbol());
		tlen = big ? 270 : $urandom_range(8, 60);
		for (int unsigned i = 0; i < tlen; i++) begin
			r = $urandom_range(0, 59);
			if (r == 0)
				send_item(FUNC_NOP, 8'($urandom));
			else if (r == 1)
				send_item(FUNC_APPEND, pick_symbol());
			else
				send_item(FUNC_TEXT, big ? alphabet[0] : pick_symbol());
		end
	endtask

	task automatic send_noise();
		int unsigned n;
		steady = 1'b0;
		n = $urandom_range(4, 16);
		for (int unsigned i = 0; i < n; i++)
			send_item(2'($urandom), 8'($urandom));
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned stall;
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(50, 200)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		kmp_result_t got;
		kmp_result_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				got = '{found: match_found, start: match_start, len: matched_length,
					status: status};
				results_checked++;
				if (got.found)
					matches_seen++;
				if (got.status == ST_FULL)
					full_seen++;
				if (got.status == ST_EMPTY)
					empty_seen++;
				if (pending_results.size() == 0) begin
					report_failure("result with nothing expected", RES_ZERO, got);
				end else begin
					want = pending_results.pop_front();
					if (got.found !== want.found || got.start !== want.start ||
							got.len !== want.len || got.status !== want.status)
						report_failure("mismatch (expected/actual)", want, got);
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles.", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_CLEAR;
		data_byte = 8'h00;
		pat_len = 0;
		build_len = 0;
		text_len = 0;
		text_pos = '0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		matches_seen = 0;
		full_seen = 0;
		empty_seen = 0;
		idle_cycles = 0;
		steady = 1'b0;
		big_done = 1'b0;
		alpha_n = 1;

		directed_rows = '{
			'{FUNC_TEXT,   8'h41, 1'b1, RES_EMPTY},
			'{FUNC_NOP,    8'hFF, 1'b1, RES_ZERO},
			'{FUNC_CLEAR,  8'hFF, 1'b1, RES_ZERO},
			'{FUNC_APPEND, 8'h00, 1'b0, RES_ZERO},
			'{FUNC_APPEND, 8'hFF, 1'b0, RES_ZERO},
			'{FUNC_APPEND, 8'h00, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h00, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'hFF, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h00, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'hFF, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h00, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'hFF, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h00, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h00, 1'b0, RES_ZERO},
			'{FUNC_NOP,    8'h5A, 1'b0, RES_ZERO},
			'{FUNC_APPEND, 8'h55, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'hFF, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h00, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'h55, 1'b0, RES_ZERO},
			'{FUNC_CLEAR,  8'hA5, 1'b1, RES_ZERO},
			'{FUNC_TEXT,   8'h12, 1'b1, RES_EMPTY},
			'{FUNC_APPEND, 8'hAA, 1'b0, RES_ZERO},
			'{FUNC_APPEND, 8'hAA, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'hAA, 1'b0, RES_ZERO},
			'{FUNC_TEXT,   8'hAA, 1'b0, RES_ZERO}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int unsigned i = 0; i < DIRECTED_ROWS; i++)
			send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
				directed_rows[i].want);

		while (items_sent < ITEM_TARGET) begin
			if (!big_done && items_sent > 900)
				run_pattern_search(1'b1);
			else if ($urandom_range(0, 99) < 14)
				send_noise();
			else
				run_pattern_search($urandom_range(0, 99) < 3);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items (directed table, pattern searches and noise); %0d results checked.",
			items_sent, results_checked);
		$display("Seen %0d matches, %0d full-store drops and %0d text bytes with no pattern.",
			matches_seen, full_seen, empty_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
